// File: rtl/core/hvmb_pkg.sv
// Shared types, constants and helper functions of the hypervector majority bundler.
`default_nettype none

package hvmb_pkg;

    // Sizes of the hypervector and of each vote counter.
    localparam int VECTOR_BITS = 16384;
    localparam int COUNT_BITS  = 8;
    localparam int WORD_BITS   = 64;
    localparam int INDEX_BITS  = 8;

    // One memory row holds the counters of one 64-bit word.
    localparam int WORD_COUNT = VECTOR_BITS / WORD_BITS;
    localparam int ADDR_BITS  = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    typedef logic signed [COUNT_BITS-1:0] count_t;
    typedef count_t [WORD_BITS-1:0] row_t;

    // Saturation limits and the two possible votes.
    localparam count_t CNT_MAX   = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam count_t CNT_MIN   = {1'b1, {(COUNT_BITS-1){1'b0}}};
    localparam count_t VOTE_UP   = count_t'(1);
    localparam count_t VOTE_DOWN = {COUNT_BITS{1'b1}};

    // Request and result payloads.
    typedef struct packed {
        logic [INDEX_BITS-1:0] word_index;
        logic [WORD_BITS-1:0]  word_bits;
        logic                  fresh;
    } req_item_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0] out_index;
        logic [WORD_BITS-1:0]  majority_bits;
    } rsp_item_t;

    // Memory row address of a word index; the index is widened before it is cut.
    function automatic logic [ADDR_BITS-1:0] word_addr(input logic [INDEX_BITS-1:0] idx);
        logic [ADDR_BITS+INDEX_BITS-1:0] ext;
        ext = {{ADDR_BITS{1'b0}}, idx};
        return ext[ADDR_BITS-1:0];
    endfunction

    // True when the word index names a word of the hypervector.
    function automatic logic word_in_range(input logic [INDEX_BITS-1:0] idx);
        logic [ADDR_BITS+INDEX_BITS-1:0] ext;
        ext = {{ADDR_BITS{1'b0}}, idx};
        return ext < (ADDR_BITS+INDEX_BITS)'(WORD_COUNT);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/hvmb_mem.sv
// Vote counter memory: one row of 64 counters per word, one read and one write port.
`default_nettype none

module hvmb_mem
    import hvmb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output row_t                      rd_data,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  row_t                      wr_data
);

    row_t counter_mem [WORD_COUNT];
    row_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            counter_mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; a read and a write of the same row in one cycle return old data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= counter_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/core/hvmb_update.sv
// Per-bit counter update with saturation, and the majority word of the updated row.
`default_nettype none

module hvmb_update
    import hvmb_pkg::*;
(
    input  row_t                      old_row,
    input  wire logic [WORD_BITS-1:0] word_bits,
    input  wire logic                 fresh,
    input  wire logic                 in_range,
    output row_t                      new_row,
    output logic [WORD_BITS-1:0]      majority
);

    // Each of the 64 lanes works on its own counter.
    always_comb
    begin
        count_t c;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            c = old_row[b];
            if (fresh)
            begin
                c = word_bits[b] ? VOTE_UP : VOTE_DOWN;
            end
            else if (word_bits[b])
            begin
                if (c != CNT_MAX)
                begin
                    c = c + VOTE_UP;
                end
            end
            else
            begin
                if (c != CNT_MIN)
                begin
                    c = c - VOTE_UP;
                end
            end
            new_row[b]  = c;
            // A bit wins only when its counter is strictly positive.
            majority[b] = in_range && !c[COUNT_BITS-1] && (c != '0);
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/hypervector_majority_bundler.sv
// Top level of the hypervector majority bundler: request pipeline, forwarding and result register.
`default_nettype none

// The block keeps one signed saturating vote counter per hypervector bit, held as one
// memory row of 64 counters per 64-bit word. A request carries a word index, the word's
// bits and a fresh flag; fresh overwrites the row with the word's +1/-1 votes, so the
// counters need no clearing after reset and a row must see a fresh request before it is
// accumulated into. The block takes one request per cycle while the result is not stalled;
// the counter memory's registered read captures the row at the accepting edge, and the
// update of all 64 counters, the write-back and the result register all take the edge at
// which the update stage advances. A stalled result holds the update stage and, once that
// is full too, the request side. A request that hits the row written in the cycle before
// gets that row from a one-deep forwarding register. A word index beyond the hypervector
// touches no counter and returns a zero word.
module hypervector_majority_bundler
    import hvmb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic item_valid,
    output logic      item_ready,
    input  req_item_t item,
    output logic      result_valid,
    input  wire logic result_ready,
    output rsp_item_t result
);

    logic                 s1_valid_reg;
    req_item_t            s1_item_reg;
    logic                 fwd_valid_reg;
    logic [ADDR_BITS-1:0] fwd_addr_reg;
    row_t                 fwd_row_reg;
    logic                 result_valid_reg;
    rsp_item_t            result_reg;

    logic                 s1_adv;
    logic                 accept;
    logic [ADDR_BITS-1:0] s1_addr;
    logic                 s1_in_range;
    logic                 wr_en;
    row_t                 rd_row;
    row_t                 old_row;
    row_t                 new_row;
    logic [WORD_BITS-1:0] majority;

    // Handshake: the update stage moves on when the result register is free or drains.
    assign s1_adv     = s1_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !s1_valid_reg || s1_adv;
    assign accept     = item_valid && item_ready;

    assign s1_addr     = word_addr(s1_item_reg.word_index);
    assign s1_in_range = word_in_range(s1_item_reg.word_index);
    assign wr_en       = s1_adv && s1_in_range;

    // Counter memory; the row is read as the request is accepted.
    hvmb_mem u_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (word_addr(item.word_index)),
        .rd_data (rd_row),
        .wr_en   (wr_en),
        .wr_addr (s1_addr),
        .wr_data (new_row)
    );

    // The last written row overrides the memory data whenever its row matches, which covers a read in the same cycle.
    assign old_row = (fwd_valid_reg && (fwd_addr_reg == s1_addr)) ? fwd_row_reg : rd_row;

    hvmb_update u_update (
        .old_row   (old_row),
        .word_bits (s1_item_reg.word_bits),
        .fresh     (s1_item_reg.fresh),
        .in_range  (s1_in_range),
        .new_row   (new_row),
        .majority  (majority)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            fwd_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                s1_valid_reg <= item_valid;
            end
            if (wr_en)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (s1_adv)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item;
        end
        if (wr_en)
        begin
            fwd_addr_reg <= s1_addr;
            fwd_row_reg  <= new_row;
        end
        if (s1_adv)
        begin
            result_reg.out_index     <= s1_item_reg.word_index;
            result_reg.majority_bits <= majority;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A stalled request in the update stage stays and keeps its payload.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_item_reg)))
        else $error("update stage lost or changed a stalled request");

    // A counter row is written only for an in-range request leaving the update stage.
    a_write_guard: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (s1_valid_reg && s1_in_range && (!result_valid_reg || result_ready)))
        else $error("counter row written without a moving in-range request");

    // The result echoes the index of the request that produced it.
    a_index_echo: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> (result_valid && result.out_index == $past(s1_item_reg.word_index)))
        else $error("result index does not match its request");

    // An index beyond the hypervector yields an all-zero word.
    a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && !s1_in_range) |=> (result.majority_bits == '0))
        else $error("out-of-range request returned a nonzero word");

endmodule

`default_nettype wire
